// ===== hw/rtl/baro_sensor_compensation_assert.svh =====
// Assertion macros shared by the compensation block RTL.
// Included by modules that check their own handshake and pipeline state.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Assert an implication on every clock edge outside reset.
`define BSC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert a condition that must hold on every clock edge outside reset.
`define BSC_ASSERT_ALWAYS(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bsc_pkg.sv =====
// Types and constants of the barometric compensation block.
// No dependencies.
package bsc_pkg;

  localparam int unsigned NumCfgRegs = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoefFirst  = 3'd0,
    CfgCoefMiddle = 3'd1,
    CfgCoefLast   = 3'd2,
    CfgPressOsr   = 3'd3,
    CfgTempOsr    = 3'd4,
    CfgTempOffset = 3'd5
  } cfg_idx_e;

  // Oversampling scale factors selected by the 3-bit code.
  function automatic logic [22:0] scale_factor(input logic [2:0] code);
    logic [22:0] k;
    case (code)
      3'd0: k = 23'd524288;
      3'd1: k = 23'd1572864;
      3'd2: k = 23'd3670016;
      3'd3: k = 23'd7864320;
      3'd4: k = 23'd253952;
      3'd5: k = 23'd516096;
      3'd6: k = 23'd1040384;
      default: k = 23'd2088960;
    endcase
    return k;
  endfunction

  // Front-to-back queue entry: scaled magnitudes with signs.
  typedef struct packed {
    logic        sp_neg;
    logic [47:0] sp_mag;
    logic        st_neg;
    logic [47:0] st_mag;
  } scaled_t;

endpackage

// ===== hw/rtl/baro_sensor_compensation.sv =====
// Barometric sensor compensation.
// Accepts raw pressure/temperature pairs on s_axis, returns compensated
// Q8 results on m_axis. Configuration by a plain write port (cfg_*).
// s_axis_tdata: raw_pressure [23:0], raw_temperature [47:24].
// m_axis_tdata: pressure_pa_q8 [31:0], temperature_c_q8 [63:32].
// m_axis_tuser: saturated [0].
// One item per cycle is accepted sustained while m_axis_tready is high;
// m_axis_tvalid rises once the item has moved through two scaling registers, one
// queue entry and ten polynomial stages into the output register.
// Unstalled stages take a new transaction per cycle, so throughput is one
// item per cycle. Reset returns registers to their defaults (coefficients
// zero, oversampling code 2, offset 30.0 C) and empties all stages.
// When m_axis_tready is low the pipelines hold; the queue absorbs the
// front's items, and s_axis_tready falls once queue and stages are full.
// Configuration must be written only while no item is in flight.
module baro_sensor_compensation #(
  parameter int unsigned SCALED_FRAC_BITS = 24,
  parameter int unsigned OUT_FRAC_BITS    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata, // raw_pressure, raw_temperature
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata, // pressure, temperature
  output logic [0:0]                   m_axis_tuser  // saturated
);
  import bsc_pkg::*;

  logic [63:0] cf_q, cm_q;
  logic [15:0] cl_q, toff_q;
  logic [2:0]  posr_q, tosr_q;
  logic        f_valid, f_ready, q_valid, q_ready;
  scaled_t     f_data, q_data;
  logic [31:0] pres, temp;
  logic        sat;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q   <= '0;
      cm_q   <= '0;
      cl_q   <= '0;
      posr_q <= 3'd2;
      tosr_q <= 3'd2;
      toff_q <= 16'd7680;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCoefFirst:  cf_q   <= cfg_data_i;
        CfgCoefMiddle: cm_q   <= cfg_data_i;
        CfgCoefLast:   cl_q   <= cfg_data_i[15:0];
        CfgPressOsr:   posr_q <= cfg_data_i[2:0];
        CfgTempOsr:    tosr_q <= cfg_data_i[2:0];
        CfgTempOffset: toff_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bsc_front #(.ScaledFracBits(SCALED_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .p_osr_i(posr_q), .t_osr_i(tosr_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .raw_p_i(s_axis_tdata[23:0]), .raw_t_i(s_axis_tdata[47:24]),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_o(f_data)
  );

  bsc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_data)
  );

  bsc_back #(.ScaledFracBits(SCALED_FRAC_BITS), .OutFracBits(OUT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .cf_i(cf_q), .cm_i(cm_q), .cl_i(cl_q), .toff_i(toff_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .pres_o(pres), .temp_o(temp), .sat_o(sat)
  );

  assign m_axis_tdata = {temp, pres};
  assign m_axis_tuser = sat;

endmodule

// ===== hw/rtl/bsc_front.sv =====
// Front part: accepts raw reading pairs and scales them by reciprocal.
// Depends on bsc_pkg.
module bsc_front #(
  parameter int unsigned ScaledFracBits = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       p_osr_i,
  input  logic [2:0]       t_osr_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [23:0]      raw_p_i,
  input  logic [23:0]      raw_t_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bsc_pkg::scaled_t out_o
);
  import bsc_pkg::*;

  // The smallest scale factor is just under 2^18, so the reciprocal needs
  // six bits above the fraction width.
  localparam int unsigned RecipW = ScaledFracBits + 6;
  localparam int unsigned ProdW  = 24 + RecipW;

  logic [RecipW-1:0] recip_p, recip_t;
  logic              s1_valid_q, s2_valid_q;
  logic              s1_pn_q, s1_tn_q;
  logic [23:0]       s1_pm_q, s1_tm_q;
  logic [RecipW-1:0] s1_rp_q, s1_rt_q;
  scaled_t           s2_q;
  logic              adv1, adv2;
  logic [ProdW-1:0]  prod_p, prod_t;

  // Reciprocal from the constant division table (elaborated per code).
  function automatic logic [RecipW-1:0] recip(input logic [2:0] code);
    logic [RecipW-1:0] r;
    case (code)
      3'd0: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd524288);
      3'd1: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd1572864);
      3'd2: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd3670016);
      3'd3: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd7864320);
      3'd4: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd253952);
      3'd5: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd516096);
      3'd6: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd1040384);
      default: r = RecipW'((64'd1 << (ScaledFracBits + 23)) / 64'd2088960);
    endcase
    return r;
  endfunction

  assign recip_p = recip(p_osr_i);
  assign recip_t = recip(t_osr_i);

  assign adv2       = !s2_valid_q || out_ready_i;
  assign adv1       = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  assign prod_p = ProdW'(s1_pm_q) * ProdW'(s1_rp_q) + (ProdW'(1) << 22);
  assign prod_t = ProdW'(s1_tm_q) * ProdW'(s1_rt_q) + (ProdW'(1) << 22);

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  // Take magnitudes, then multiply by reciprocal and round.
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_pn_q <= raw_p_i[23];
      s1_tn_q <= raw_t_i[23];
      s1_pm_q <= raw_p_i[23] ? 24'(-raw_p_i) : raw_p_i;
      s1_tm_q <= raw_t_i[23] ? 24'(-raw_t_i) : raw_t_i;
      s1_rp_q <= recip_p;
      s1_rt_q <= recip_t;
    end
    if (adv2 && s1_valid_q) begin
      s2_q.sp_neg <= s1_pn_q;
      s2_q.st_neg <= s1_tn_q;
      s2_q.sp_mag <= 48'(prod_p >> 23);
      s2_q.st_mag <= 48'(prod_t >> 23);
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

// ===== hw/rtl/bsc_queue.sv =====
// Short queue between the front and back parts of the compensation block.
// Depends on bsc_pkg and the assertion header.
`include "baro_sensor_compensation_assert.svh"
module bsc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  bsc_pkg::scaled_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output bsc_pkg::scaled_t rd_data_o
);
  import bsc_pkg::*;

  scaled_t    mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr_en, rd_en;

  assign wr_ready_o = cnt_q != 3'd4;
  assign rd_valid_o = cnt_q != 3'd0;
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wp_q <= wp_q + 2'd1;
      if (rd_en) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end

  `BSC_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= 3'd4)
  `BSC_ASSERT_IMPL(a_ptr_gap, clk_i, rst_ni, cnt_q == 3'd0, wp_q == rp_q)
  `BSC_ASSERT_IMPL(a_cnt_step, clk_i, rst_ni, wr_en && !rd_en,
                   ##1 cnt_q == $past(cnt_q) + 3'd1)

endmodule

// ===== hw/rtl/bsc_back.sv =====
// Back part: polynomial evaluation, output rounding and saturation.
// Depends on bsc_pkg and the assertion header.
`include "baro_sensor_compensation_assert.svh"
module bsc_back #(
  parameter int unsigned ScaledFracBits = 24,
  parameter int unsigned OutFracBits    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      cf_i,
  input  logic [63:0]      cm_i,
  input  logic [15:0]      cl_i,
  input  logic [15:0]      toff_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bsc_pkg::scaled_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      pres_o,
  output logic [31:0]      temp_o,
  output logic             sat_o
);
  import bsc_pkg::*;

  localparam int unsigned F     = ScaledFracBits;
  localparam int unsigned Sh    = F - OutFracBits;
  localparam int unsigned NStg  = 10;
  // Scaled magnitudes stay below 2^(F+6).
  localparam int unsigned SpW   = F + 6;
  // Partial product width: 32-bit accumulator half times scaled magnitude.
  localparam int unsigned PW    = 32 + SpW;
  localparam logic [63:0] Max64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // Pipeline record.
  typedef struct packed {
    logic signed [63:0] sp;
    logic signed [63:0] st;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] t;
    logic               na;
    logic               nb;
    logic [PW-1:0]      pah;
    logic [PW-1:0]      pal;
    logic [PW-1:0]      pbh;
    logic [PW-1:0]      pbl;
    logic               sat;
  } stg_t;

  stg_t       stg_q [NStg];
  stg_t       stg_d [NStg];
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] adv;
  logic       ov_q, osat_q;
  logic [31:0] op_q, ot_q;
  logic       oadv;

  logic signed [63:0] c0h, c00, c10, c01, c11, c20;
  logic signed [63:0] one_s;

  assign c0h = $signed(64'(signed'(cf_i[63:52]))) / 64'sd2;
  assign c00 = 64'(signed'(cf_i[39:20]));
  assign c10 = 64'(signed'(cf_i[19:0]));
  assign c01 = 64'(signed'(cm_i[63:48]));
  assign c11 = 64'(signed'(cm_i[47:32]));
  assign c20 = 64'(signed'(cm_i[31:16]));
  assign one_s = 64'sd1 <<< F;

  // Saturating add to +-(2^63-1).
  function automatic logic [64:0] sadd(input logic signed [63:0] x,
                                        input logic signed [63:0] y);
    logic signed [64:0] s;
    logic [64:0] r;
    s = 65'(x) + 65'(y);
    if (s > $signed({1'b0, Max64}))       r = {1'b1, Max64};
    else if (s < -$signed({1'b0, Max64})) r = {1'b1, 64'(-Max64)};
    else                                   r = {1'b0, s[63:0]};
    return r;
  endfunction

  // First half of the fixed-point product: split the accumulator magnitude
  // into two 32-bit halves and multiply each by the scaled magnitude.
  // Packs {sign, high partial, low partial}.
  function automatic logic [2*PW:0] mul_part(input logic signed [63:0] x,
                                             input logic signed [63:0] y);
    logic [63:0]   mx, my;
    logic [PW-1:0] lo, hi;
    mx = x[63] ? 64'(-x) : x;
    my = y[63] ? 64'(-y) : y;
    lo = PW'(mx[31:0]) * PW'(my[SpW-1:0]);
    hi = PW'(mx[63:32]) * PW'(my[SpW-1:0]);
    return {x[63] ^ y[63], hi, lo};
  endfunction

  // Second half: sum the partials, round and clip; bit 64 marks a clip.
  function automatic logic [64:0] mul_fin(input logic neg, input logic [PW-1:0] hi,
                                          input logic [PW-1:0] lo);
    logic [63:0]  res;
    logic [127:0] p;
    logic         c;
    p = (128'(hi) << 32) + 128'(lo) + (128'd1 << (F - 1));
    c = 1'b0;
    if ((p >> (F + 64)) != 128'd0) begin
      c = 1'b1; res = Max64;
    end else begin
      res = 64'(p >> F);
    end
    if (res > Max64) begin
      c = 1'b1; res = Max64;
    end
    return {c, neg ? 64'(-res) : res};
  endfunction

  // Round and clip to the 32-bit output; bit 32 marks a clip.
  function automatic logic [32:0] to_out(input logic signed [63:0] v);
    logic [63:0] m;
    logic [32:0] r;
    m = v[63] ? 64'(-v) : v;
    if (Sh > 0) m = (m >> Sh) + ((m >> (Sh - 1)) & 64'd1);
    if (v[63]) begin
      if (m > 64'd2147483648) r = {1'b1, 32'h8000_0000};
      else                    r = {1'b0, 32'(-m)};
    end else begin
      if (m > 64'd2147483647) r = {1'b1, 32'h7FFF_FFFF};
      else                    r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

  logic [64:0] r0a, r0b, r1, r2, r3, r4, r5, r6, r7, r8;
  logic [2*PW:0] ma2, mb2, ma5, mb5;
  logic signed [SpW:0]    sp_n, st_n;
  logic signed [SpW+16:0] pa0, pb0;
  logic signed [SpW+12:0] pt0;
  logic [32:0] op, ot;

  assign sp_n = in_i.sp_neg ? -$signed({1'b0, in_i.sp_mag[SpW-1:0]})
                            :  $signed({1'b0, in_i.sp_mag[SpW-1:0]});
  assign st_n = in_i.st_neg ? -$signed({1'b0, in_i.st_mag[SpW-1:0]})
                            :  $signed({1'b0, in_i.st_mag[SpW-1:0]});

  // Narrow coefficient products for the first stage.
  assign pa0 = (SpW+17)'($signed(cl_i)) * (SpW+17)'(sp_n);
  assign pb0 = (SpW+17)'($signed(cm_i[15:0])) * (SpW+17)'(sp_n);
  assign pt0 = (SpW+13)'($signed(cf_i[51:40])) * (SpW+13)'(st_n);

  // Stage datapath: each accumulator product is split over two stages.
  always_comb begin
    stg_d = stg_q;
    // Stage 0: coefficient times scaled values, temperature line.
    stg_d[0].sp  = 64'(sp_n);
    stg_d[0].st  = 64'(st_n);
    stg_d[0].a   = 64'(pa0);
    stg_d[0].b   = 64'(pb0);
    stg_d[0].t   = c0h * one_s + 64'(pt0)
                   + $signed(64'(signed'(toff_i))) * (64'sd1 <<< (F - 8));
    stg_d[0].sat = 1'b0;
    // Stage 1: add c20 and c11.
    r0a = sadd(c20 * one_s, stg_q[0].a);
    r0b = sadd(c11 * one_s, stg_q[0].b);
    stg_d[1] = stg_q[0];
    stg_d[1].a = r0a[63:0];
    stg_d[1].b = r0b[63:0];
    stg_d[1].sat = r0a[64] | r0b[64];
    // Stages 2 and 3: both accumulators times sp.
    ma2 = mul_part(stg_q[1].a, stg_q[1].sp);
    mb2 = mul_part(stg_q[1].b, stg_q[1].sp);
    stg_d[2] = stg_q[1];
    stg_d[2].na  = ma2[2*PW];
    stg_d[2].pah = ma2[2*PW-1:PW];
    stg_d[2].pal = ma2[PW-1:0];
    stg_d[2].nb  = mb2[2*PW];
    stg_d[2].pbh = mb2[2*PW-1:PW];
    stg_d[2].pbl = mb2[PW-1:0];
    r1 = mul_fin(stg_q[2].na, stg_q[2].pah, stg_q[2].pal);
    r2 = mul_fin(stg_q[2].nb, stg_q[2].pbh, stg_q[2].pbl);
    stg_d[3] = stg_q[2];
    stg_d[3].a = r1[63:0];
    stg_d[3].b = r2[63:0];
    stg_d[3].sat = stg_q[2].sat | r1[64] | r2[64];
    // Stage 4: add c10 and c01.
    r3 = sadd(c10 * one_s, stg_q[3].a);
    r4 = sadd(c01 * one_s, stg_q[3].b);
    stg_d[4] = stg_q[3];
    stg_d[4].a = r3[63:0];
    stg_d[4].b = r4[63:0];
    stg_d[4].sat = stg_q[3].sat | r3[64] | r4[64];
    // Stages 5 and 6: a times sp, b times st.
    ma5 = mul_part(stg_q[4].a, stg_q[4].sp);
    mb5 = mul_part(stg_q[4].b, stg_q[4].st);
    stg_d[5] = stg_q[4];
    stg_d[5].na  = ma5[2*PW];
    stg_d[5].pah = ma5[2*PW-1:PW];
    stg_d[5].pal = ma5[PW-1:0];
    stg_d[5].nb  = mb5[2*PW];
    stg_d[5].pbh = mb5[2*PW-1:PW];
    stg_d[5].pbl = mb5[PW-1:0];
    r5 = mul_fin(stg_q[5].na, stg_q[5].pah, stg_q[5].pal);
    r6 = mul_fin(stg_q[5].nb, stg_q[5].pbh, stg_q[5].pbl);
    stg_d[6] = stg_q[5];
    stg_d[6].a = r5[63:0];
    stg_d[6].b = r6[63:0];
    stg_d[6].sat = stg_q[5].sat | r5[64] | r6[64];
    // Stages 7 and 8: add c00, then the temperature-dependent branch.
    r7 = sadd(c00 * one_s, stg_q[6].a);
    stg_d[7] = stg_q[6];
    stg_d[7].a = r7[63:0];
    stg_d[7].sat = stg_q[6].sat | r7[64];
    r8 = sadd(stg_q[7].a, stg_q[7].b);
    stg_d[8] = stg_q[7];
    stg_d[8].a = r8[63:0];
    stg_d[8].sat = stg_q[7].sat | r8[64];
    // Stage 9: hold before output rounding.
    stg_d[9] = stg_q[8];
    op = to_out(stg_q[NStg-1].a);
    ot = to_out(stg_q[NStg-1].t);
  end

  assign oadv = !ov_q || out_ready_i;
  always_comb begin
    adv[NStg-1] = !v_q[NStg-1] || oadv;
    for (int i = NStg - 2; i >= 0; i--) adv[i] = !v_q[i] || adv[i+1];
  end
  assign in_ready_o = adv[0];

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NStg; i++) if (adv[i]) v_q[i] <= v_q[i-1];
      if (oadv) ov_q <= v_q[NStg-1];
    end
  end

  // Hold stage payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NStg; i++) if (adv[i]) stg_q[i] <= stg_d[i];
    if (oadv && v_q[NStg-1]) begin
      op_q   <= op[31:0];
      ot_q   <= ot[31:0];
      osat_q <= stg_q[NStg-1].sat | op[32] | ot[32];
    end
  end

  assign out_valid_o = ov_q;
  assign pres_o      = op_q;
  assign temp_o      = ot_q;
  assign sat_o       = osat_q;

  `BSC_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, ov_q && !out_ready_i,
                   ##1 ov_q && $stable(op_q))
  `BSC_ASSERT_IMPL(a_last_fill, clk_i, rst_ni, v_q[NStg-1] && oadv, ##1 ov_q)
  `BSC_ASSERT_IMPL(a_in_stall, clk_i, rst_ni, !adv[0], v_q[0])

endmodule
